// ===== rtl/sps_pkg.sv =====
// ----------------------------------------------------------------------------
// sps_pkg
// Shared constants and the cordic angle table for the station phase shift core
// ----------------------------------------------------------------------------
package sps_pkg;

  localparam int OUT_BITS_DEF      = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_ENTRIES      = 24;

  // cordic start value (gain compensation), q30
  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

  // register indexes
  localparam logic [1:0] REG_PHASE_SCALE = 2'd0;
  localparam logic [1:0] REG_STEP_RATIO  = 2'd1;
  localparam logic [1:0] REG_STEP_ENABLE = 2'd2;

  // truncated atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_turns(input logic [4:0] idx);
    case (idx)
      5'd0:  atan_turns = 32'h20000000;
      5'd1:  atan_turns = 32'h12E4051D;
      5'd2:  atan_turns = 32'h09FB385B;
      5'd3:  atan_turns = 32'h051111D4;
      5'd4:  atan_turns = 32'h028B0D43;
      5'd5:  atan_turns = 32'h0145D7E1;
      5'd6:  atan_turns = 32'h00A2F61E;
      5'd7:  atan_turns = 32'h00517C55;
      5'd8:  atan_turns = 32'h0028BE53;
      5'd9:  atan_turns = 32'h00145F2F;
      5'd10: atan_turns = 32'h000A2F98;
      5'd11: atan_turns = 32'h000517CC;
      5'd12: atan_turns = 32'h00028BE6;
      5'd13: atan_turns = 32'h000145F3;
      5'd14: atan_turns = 32'h0000A2F9;
      5'd15: atan_turns = 32'h0000517C;
      5'd16: atan_turns = 32'h000028BE;
      5'd17: atan_turns = 32'h0000145F;
      5'd18: atan_turns = 32'h00000A2F;
      5'd19: atan_turns = 32'h00000517;
      5'd20: atan_turns = 32'h0000028B;
      5'd21: atan_turns = 32'h00000145;
      5'd22: atan_turns = 32'h000000A2;
      5'd23: atan_turns = 32'h00000051;
      default: atan_turns = 32'h0;
    endcase
  endfunction

endpackage

// ===== rtl/sps_cordic.sv =====
// ----------------------------------------------------------------------------
// sps_cordic
// Pipelined cordic: turn fraction in, rounded and saturated cos and sin out
// ----------------------------------------------------------------------------
module sps_cordic #(
  parameter int OUT_BITS      = sps_pkg::OUT_BITS_DEF,
  parameter int CORDIC_STAGES = sps_pkg::CORDIC_STAGES_DEF
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [31:0]                phase,
  output logic signed [OUT_BITS-1:0] cos_o,
  output logic signed [OUT_BITS-1:0] sin_o
);
  import sps_pkg::*;

  localparam int NS = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
  localparam logic signed [OUT_BITS-1:0] MAXV = {1'b0, {(OUT_BITS-1){1'b1}}};
  localparam logic signed [OUT_BITS-1:0] MINV = {1'b1, {(OUT_BITS-1){1'b0}}};

  logic signed [33:0] x_r [0:NS];
  logic signed [33:0] y_r [0:NS];
  logic signed [32:0] z_r [0:NS];
  logic [1:0]         q_r [0:NS];
  logic signed [33:0] c_r, s_r;

  // quadrant split and residual angle
  logic [1:0]  q_in;
  logic [31:0] ru;
  always_comb begin
    q_in = 2'((phase + 32'h20000000) >> 30);
    ru   = phase - {q_in, 30'd0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= GAIN_Q30;
      y_r[0] <= '0;
      z_r[0] <= {ru[31], ru};
      q_r[0] <= q_in;
    end
  end

  // one rotation per stage
  for (genvar i = 0; i < NS; i++) begin : g_stage
    logic signed [33:0] dx, dy;
    logic signed [32:0] at;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;
    assign at = {1'b0, atan_turns(5'(i))};
    always_ff @(posedge clk) begin
      if (en) begin
        q_r[i+1] <= q_r[i];
        if (!z_r[i][32]) begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - at;
        end else begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + at;
        end
      end
    end
  end

  // quadrant fold
  always_ff @(posedge clk) begin
    if (en) begin
      case (q_r[NS])
        2'd0: begin c_r <= x_r[NS];  s_r <= y_r[NS];  end
        2'd1: begin c_r <= -y_r[NS]; s_r <= x_r[NS];  end
        2'd2: begin c_r <= -x_r[NS]; s_r <= -y_r[NS]; end
        default: begin c_r <= y_r[NS]; s_r <= -x_r[NS]; end
      endcase
    end
  end

  // round half up and saturate
  function automatic logic signed [OUT_BITS-1:0] to_out(input logic signed [33:0] v);
    logic signed [34:0] t;
    logic signed [34:0] r;
    t = 35'(v) + (35'sd1 <<< (30 - OUT_BITS));
    r = t >>> (31 - OUT_BITS);
    if (r > 35'(MAXV)) to_out = MAXV;
    else if (r < 35'(MINV)) to_out = MINV;
    else to_out = r[OUT_BITS-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      cos_o <= to_out(c_r);
      sin_o <= to_out(s_r);
    end
  end

endmodule

// ===== rtl/station_phase_shift_core.sv =====
// ----------------------------------------------------------------------------
// station_phase_shift_core
// Station phase term: dot product, phase scaling, step phase, two cordics
// ----------------------------------------------------------------------------
// One word in and one word out per cycle unless the output stalls. Words
// pass the dot product (input register, products, sum), then phase and step
// multiplication (32x32 partial products, phase, step partial products, step
// phase), then the cordic pipelines. The whole pipeline advances only when the
// output register is free or being taken, so a stall holds every stage in place.
module station_phase_shift_core #(
  parameter int OUT_BITS      = sps_pkg::OUT_BITS_DEF,
  parameter int CORDIC_STAGES = sps_pkg::CORDIC_STAGES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_addr,
  input  logic [31:0]              cfg_wdata,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // coord_u[29:0], coord_v[59:30], coord_w[89:60], dir_l[121:90],
  // dir_m[153:122], dir_n[185:154], zero fill to 192
  input  logic [191:0]             in_tdata,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // cos_base, sin_base, cos_step, sin_step (OUT_BITS each), step_valid, fill
  output logic [((4*OUT_BITS+1+7)/8)*8-1:0] out_tdata
);
  import sps_pkg::*;

  localparam int NS  = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
  localparam int LAT = NS + 10;

  logic [31:0] phase_scale_r, step_ratio_r;
  logic        step_enable_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_scale_r <= '0;
      step_ratio_r  <= '0;
      step_enable_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_PHASE_SCALE: phase_scale_r <= cfg_wdata;
        REG_STEP_RATIO:  step_ratio_r  <= cfg_wdata;
        REG_STEP_ENABLE: step_enable_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // pipeline advance
  logic adv;
  logic [LAT-1:0] vld_r;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[LAT-2:0], in_tvalid};
  end
  assign out_tvalid = vld_r[LAT-1];

  // step enable travels with the word
  logic [LAT-1:0] sen_r;
  always_ff @(posedge clk) begin
    if (adv) sen_r <= {sen_r[LAT-2:0], step_enable_r};
  end

  // stage 1: input register
  logic signed [29:0] u_r, v_r, w_r;
  logic signed [31:0] l_r, m_r;
  logic signed [32:0] nm_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      u_r  <= in_tdata[29:0];
      v_r  <= in_tdata[59:30];
      w_r  <= in_tdata[89:60];
      l_r  <= in_tdata[121:90];
      m_r  <= in_tdata[153:122];
      nm_r <= 33'(signed'(in_tdata[185:154])) - 33'sd1073741824;
    end
  end

  // stage 2: three products
  logic signed [61:0] pu_r, pv_r;
  logic signed [62:0] pw_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      pu_r <= u_r * l_r;
      pv_r <= v_r * m_r;
      pw_r <= w_r * nm_r;
    end
  end

  // stage 3: sum
  logic signed [63:0] d_r;
  always_ff @(posedge clk) begin
    if (adv) d_r <= 64'(pu_r) + 64'(pv_r) + 64'(pw_r);
  end

  // stage 4: partial products of d times phase_scale
  logic [63:0] pa_r, pb_r;
  logic [31:0] ps4_r;
  logic        dneg_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      pa_r   <= 64'(d_r[31:0]) * 64'(phase_scale_r);
      pb_r   <= 64'(d_r[63:32]) * 64'(phase_scale_r);
      ps4_r  <= phase_scale_r;
      dneg_r <= d_r[63];
    end
  end

  // stage 5: combine into phase (bits 30..93 of signed product)
  logic [95:0] prod;
  logic [63:0] ph_r;
  always_comb begin
    prod = 96'(pa_r) + {pb_r, 32'd0};
    if (dneg_r) prod = prod - {ps4_r, 64'd0};
  end
  always_ff @(posedge clk) begin
    if (adv) ph_r <= prod[93:30];
  end

  // stage 6: step partial products (low 64 of ph*ratio, bits 32..63 needed)
  logic [63:0] sa_r;
  logic [31:0] sb_r;
  logic [31:0] ph6_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      sa_r  <= 64'(ph_r[31:0]) * 64'(step_ratio_r);
      sb_r  <= 32'(ph_r[63:32] * step_ratio_r);
      ph6_r <= ph_r[31:0];
    end
  end

  // stage 7: step phase
  logic [31:0] sp_r, pb7_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      sp_r  <= sa_r[63:32] + sb_r;
      pb7_r <= ph6_r;
    end
  end

  // cordics
  logic signed [OUT_BITS-1:0] cb, sb, cs, ss;
  sps_cordic #(.OUT_BITS(OUT_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_cordic_base (
    .clk(clk), .en(adv), .phase(pb7_r), .cos_o(cb), .sin_o(sb)
  );
  sps_cordic #(.OUT_BITS(OUT_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_cordic_step (
    .clk(clk), .en(adv), .phase(sp_r), .cos_o(cs), .sin_o(ss)
  );

  // output word
  logic se;
  assign se = sen_r[LAT-1];
  always_comb begin
    out_tdata = '0;
    out_tdata[OUT_BITS-1:0]            = cb;
    out_tdata[2*OUT_BITS-1:OUT_BITS]   = sb;
    out_tdata[3*OUT_BITS-1:2*OUT_BITS] = se ? cs : '0;
    out_tdata[4*OUT_BITS-1:3*OUT_BITS] = se ? ss : '0;
    out_tdata[4*OUT_BITS]              = se;
  end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for station_phase_shift_core: drives coordinate and
// direction words with random idling and stalls, predicts cos/sin of the base
// and step phases, and compares each output word in order
// ----------------------------------------------------------------------------
module testbench;
  import sps_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;  // unused index, write is dropped
  localparam int         PIPE_WAIT = 40;    // a bit over the pipeline latency
  localparam int         OUT_W     = 72;

  // truncated atan(2^-i) in 2^-32 turn
  localparam logic [31:0] ANGLES [16] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C};

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_addr = '0;
  logic [31:0]       cfg_wdata = '0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [191:0]      in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;

  // shadow of the block's registers
  logic [31:0] phase_scale_q = '0;
  logic [31:0] step_ratio_q  = '0;
  logic        step_en_q     = 1'b0;

  logic [191:0]     samples_pending [$];
  logic [OUT_W-1:0] terms_expected  [$];
  int  idle_pct = 37;
  int  hold_reqs = 0;
  int  hold_done = 0;
  int  hold_cnt = 0;
  int  in_accepts = 0;
  int  acc_mark = 0;
  bit  failed = 1'b0;

  station_phase_shift_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // round half up to q1.15 and saturate
  function automatic logic [15:0] to_q15(longint v);
    longint r;
    r = (v + 64'sd16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  // quadrant split, cordic rotation, then quadrant fold, returns {sin, cos}
  function automatic logic [31:0] cos_sin(logic [31:0] p);
    logic [31:0] q, ru;
    longint x, y, z, dx, dy, c, s;
    q = ((p + 32'h20000000) >> 30) & 32'd3;
    ru = p - (q << 30);
    z = longint'($signed(ru));
    x = 64'sd652032874;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ANGLES[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ANGLES[i]);
      end
    end
    case (q[1:0])
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    return {to_q15(s), to_q15(c)};
  endfunction

  // expected output word for one sample word
  function automatic logic [OUT_W-1:0] phase_terms(logic [191:0] w);
    longint u, v, ww, l, m, n, d;
    logic signed [127:0] a, b, pr;
    logic [63:0] ph, sp;
    logic [31:0] base, stp;
    u  = longint'($signed(w[29:0]));
    v  = longint'($signed(w[59:30]));
    ww = longint'($signed(w[89:60]));
    l  = longint'($signed(w[121:90]));
    m  = longint'($signed(w[153:122]));
    n  = longint'($signed(w[185:154]));
    d = u * l + v * m + ww * (n - 64'sd1073741824);
    a = d;
    b = {96'b0, phase_scale_q};
    pr = a * b;
    ph = pr[93:30];
    base = cos_sin(ph[31:0]);
    if (step_en_q) begin
      sp = ph * {32'b0, step_ratio_q};
      stp = cos_sin(sp[63:32]);
      return {7'b0, 1'b1, stp, base};
    end
    return {7'b0, 1'b0, 32'b0, base};
  endfunction

  function automatic logic [191:0] pack_sample(logic [29:0] u, logic [29:0] v,
      logic [29:0] w, logic [31:0] l, logic [31:0] m, logic [31:0] n);
    return {6'b0, n, m, l, w, v, u};
  endfunction

  // register write, block must be idle
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_PHASE_SCALE: phase_scale_q = val;
      REG_STEP_RATIO:  step_ratio_q = val;
      REG_STEP_ENABLE: step_en_q = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    wait (samples_pending.size() == 0 && terms_expected.size() == 0);
    repeat (PIPE_WAIT) @(posedge clk);
  endtask

  task automatic set_regs(logic [31:0] sc, logic [31:0] ra, logic en);
    drain();
    write_reg(REG_PHASE_SCALE, sc);
    write_reg(REG_STEP_RATIO, ra);
    write_reg(REG_STEP_ENABLE, {31'b0, en});
  endtask

  // random sample: full bit patterns or direction components each within -1 to 1 (q30)
  task automatic push_random(int cnt);
    logic [31:0] l, m, n;
    for (int k = 0; k < cnt; k++) begin
      if ($urandom_range(3) == 0) begin
        l = $urandom; m = $urandom; n = $urandom;
      end else begin
        l = $urandom_range(32'h80000000) - 32'h40000000;
        m = $urandom_range(32'h80000000) - 32'h40000000;
        n = $urandom_range(32'h80000000) - 32'h40000000;
      end
      samples_pending.push_back(pack_sample(30'($urandom), 30'($urandom), 30'($urandom),
                                            l, m, n));
    end
  endtask

  // driver: hold a waiting word, otherwise offer the next one or idle
  always @(negedge clk) begin
    if (in_tvalid && in_accepts == acc_mark) begin
      // word still waiting for the block
    end else if (samples_pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
      in_tvalid <= 1'b1;
      in_tdata <= samples_pending[0];
      acc_mark <= in_accepts;
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // receiver with long hold-off on request
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_tready <= 1'b0;
    end else if (hold_reqs != hold_done) begin
      hold_done <= hold_done + 1;
      hold_cnt <= 300;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // monitor: record accepted samples, check output words
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      terms_expected.push_back(phase_terms(in_tdata));
      void'(samples_pending.pop_front());
      in_accepts <= in_accepts + 1;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (terms_expected.size() == 0) begin
        $display("%0t: unexpected word %h", $realtime, out_tdata);
        failed = 1'b1;
      end else begin
        if (out_tdata[15:0] !== terms_expected[0][15:0]) begin
          $display("%0t: cos_base exp %h got %h", $realtime,
                   terms_expected[0][15:0], out_tdata[15:0]);
          failed = 1'b1;
        end
        if (out_tdata[31:16] !== terms_expected[0][31:16]) begin
          $display("%0t: sin_base exp %h got %h", $realtime,
                   terms_expected[0][31:16], out_tdata[31:16]);
          failed = 1'b1;
        end
        if (out_tdata[47:32] !== terms_expected[0][47:32]) begin
          $display("%0t: cos_step exp %h got %h", $realtime,
                   terms_expected[0][47:32], out_tdata[47:32]);
          failed = 1'b1;
        end
        if (out_tdata[63:48] !== terms_expected[0][63:48]) begin
          $display("%0t: sin_step exp %h got %h", $realtime,
                   terms_expected[0][63:48], out_tdata[63:48]);
          failed = 1'b1;
        end
        if (out_tdata[64] !== terms_expected[0][64]) begin
          $display("%0t: step_valid exp %b got %b", $realtime,
                   terms_expected[0][64], out_tdata[64]);
          failed = 1'b1;
        end
        void'(terms_expected.pop_front());
      end
    end
  end

  // stimulus
  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset values: all zero phases, step off
    samples_pending.push_back(pack_sample(30'h1FFFFFFF, 30'h20000000, 30'h1,
                                          32'h40000000, 32'hC0000000, 32'h0));
    // phase equals l: quadrant and eighth-turn boundaries
    set_regs(32'h40000000, 32'h80000000, 1'b1);
    samples_pending.push_back(pack_sample(30'd1, 30'd0, 30'd0, 32'h00000000, 32'd0, 32'd0));
    samples_pending.push_back(pack_sample(30'd1, 30'd0, 30'd0, 32'h20000000, 32'd0, 32'd0));
    samples_pending.push_back(pack_sample(30'd1, 30'd0, 30'd0, 32'h1FFFFFFF, 32'd0, 32'd0));
    samples_pending.push_back(pack_sample(30'd1, 30'd0, 30'd0, 32'h40000000, 32'd0, 32'd0));
    samples_pending.push_back(pack_sample(30'd1, 30'd0, 30'd0, 32'h60000000, 32'd0, 32'd0));
    samples_pending.push_back(pack_sample(30'd1, 30'd0, 30'd0, 32'h80000000, 32'd0, 32'd0));
    samples_pending.push_back(pack_sample(30'd1, 30'd0, 30'd0, 32'hC0000000, 32'd0, 32'd0));
    samples_pending.push_back(pack_sample(30'd1, 30'd0, 30'd0, 32'hE0000000, 32'd0, 32'd0));
    samples_pending.push_back(pack_sample(30'd1, 30'd0, 30'd0, 32'hFFFFFFFF, 32'd0, 32'd0));
    // w term with n at one and minus one
    samples_pending.push_back(pack_sample(30'd0, 30'd0, 30'h1FFFFFFF, 32'd0, 32'd0, 32'h40000000));
    samples_pending.push_back(pack_sample(30'd0, 30'd0, 30'h20000000, 32'd0, 32'd0, 32'hC0000000));

    // field extremes with largest scale and ratio; spare index is dropped
    set_regs(32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1);
    write_reg(REG_SPARE, 32'hFFFFFFFF);
    samples_pending.push_back(pack_sample(30'h1FFFFFFF, 30'h1FFFFFFF, 30'h1FFFFFFF,
                                          32'h40000000, 32'h40000000, 32'h40000000));
    samples_pending.push_back(pack_sample(30'h20000000, 30'h20000000, 30'h20000000,
                                          32'hC0000000, 32'hC0000000, 32'hC0000000));
    samples_pending.push_back(pack_sample(30'h20000000, 30'h20000000, 30'h20000000,
                                          32'h80000000, 32'h80000000, 32'h80000000));
    samples_pending.push_back(pack_sample(30'h1FFFFFFF, 30'h1FFFFFFF, 30'h1FFFFFFF,
                                          32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
    samples_pending.push_back(pack_sample('1, '1, '1, '1, '1, '1));

    // random phases, one long stretch without idling
    set_regs($urandom, $urandom, 1'b1);
    push_random(100);
    idle_pct = 0;
    push_random(100);
    wait (samples_pending.size() == 0);
    idle_pct = 37;

    // receiver hold-off while words keep coming
    set_regs($urandom, $urandom, 1'b0);
    hold_reqs = hold_reqs + 1;
    push_random(100);

    set_regs(32'h00000001, 32'h00000001, 1'b1);
    push_random(60);
    set_regs($urandom, 32'h0, 1'b1);
    push_random(60);
    set_regs(32'h0, $urandom, 1'b1);
    push_random(40);
    set_regs($urandom, $urandom, 1'b1);
    push_random(140);

    drain();
    if (!failed) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // timeout
  initial begin
    #4000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== station_phase_shift_core.f =====
rtl/sps_pkg.sv
rtl/sps_cordic.sv
rtl/station_phase_shift_core.sv
verif/testbench.sv
